// File: src/sas_pkg.sv
// Package with the shared types, constants and codes of the sprite animation sequencer.
`timescale 1ns / 1ps

package sas_pkg;

  localparam int NUM_ANIMATIONS = 16;
  localparam int ANIM_BITS      = 4;
  localparam int COUNT_BITS     = 5;
  localparam int FRAME_BITS     = 8;
  localparam int TILE_BITS      = 9;
  localparam int CMD_BITS       = 3;
  localparam int OPT_BITS       = 3;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 9;

  localparam logic [TILE_BITS-1:0] TILE_COUNT_RESET = TILE_BITS'(256);

  localparam logic [CMD_BITS-1:0] CMD_TICK        = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_DEFINE      = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_SELECT      = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_STEP_BACK   = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_SET_AUTO    = 3'd4;
  localparam logic [CMD_BITS-1:0] CMD_SET_VISIBLE = 3'd5;

  localparam logic [OPT_BITS-1:0] OPT_LOOP    = 3'd0;
  localparam logic [OPT_BITS-1:0] OPT_NEXT    = 3'd1;
  localparam logic [OPT_BITS-1:0] OPT_HOLD    = 3'd2;
  localparam logic [OPT_BITS-1:0] OPT_HIDE    = 3'd3;
  localparam logic [OPT_BITS-1:0] OPT_DEFAULT = 3'd4;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_DEFAULT_ANIM = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TILE_COUNT   = 1'b1;

  typedef struct packed {
    logic [CMD_BITS-1:0]   command;
    logic [ANIM_BITS-1:0]  anim_index;
    logic [FRAME_BITS-1:0] start_frame;
    logic [FRAME_BITS-1:0] end_frame;
    logic [OPT_BITS-1:0]   end_option;
    logic                  flag_value;
  } sas_in_t;

  typedef struct packed {
    logic [ANIM_BITS-1:0]  cur_animation;
    logic [FRAME_BITS-1:0] cur_frame;
    logic                  visible;
    logic                  auto_animate;
    logic                  ok;
  } sas_out_t;

  typedef struct packed {
    logic [FRAME_BITS-1:0] start_frame;
    logic [FRAME_BITS-1:0] end_frame;
    logic [OPT_BITS-1:0]   end_option;
  } sas_entry_t;

  typedef struct packed {
    logic                 en;
    logic [ANIM_BITS-1:0] idx;
    sas_entry_t           entry;
  } sas_tbl_wr_t;

endpackage

// File: src/sprite_animation_sequencer_top.sv
// Top level of the sprite animation sequencer: configuration, handshakes and result register.
//
//   Channel   Signals                                  Carries
//   cmd       cmd_valid, cmd_ready, cmd_data           one command per transfer
//   rsp       rsp_valid, rsp_ready, rsp_data           one result per command
//   cfg       cfg_valid, cfg_ready, cfg_index, cfg_data register write
//
// The result of every command is in the result register on the next cycle.
// A new command is taken in every cycle while the result register is empty or being read.
// When the result waits on rsp_ready, cmd_ready is low and the state does not move.
// Reset empties the result register and returns all state and registers to their defaults.
`timescale 1ns / 1ps

module sprite_animation_sequencer_top
  import sas_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  output logic                      cmd_ready,
  input  sas_in_t                   cmd_data,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output sas_out_t                  rsp_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  logic [ANIM_BITS-1:0]  default_anim;
  logic [TILE_BITS-1:0]  tile_count;
  logic                  fire;
  logic [ANIM_BITS-1:0]  rd_addr;
  sas_entry_t            rd_entry;
  logic [COUNT_BITS-1:0] count;
  sas_tbl_wr_t           wr;
  sas_out_t              result;

  assign cfg_ready = 1'b1;
  assign cmd_ready = !rsp_valid || rsp_ready;
  assign fire      = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_anim <= '0;
      tile_count   <= TILE_COUNT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DEFAULT_ANIM: default_anim <= cfg_data[ANIM_BITS-1:0];
        CFG_TILE_COUNT:   tile_count   <= cfg_data[TILE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  sas_seq_table u_table (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .count    (count)
  );

  sas_core u_core (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .cmd          (cmd_data),
    .default_anim (default_anim),
    .tile_count   (tile_count),
    .rd_addr      (rd_addr),
    .rd_entry     (rd_entry),
    .count        (count),
    .wr           (wr),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_data <= result;
    end
  end

endmodule

// File: src/sas_seq_table.sv
// Sequence table with per-entry valid bits, defined count and one read port.
`timescale 1ns / 1ps

module sas_seq_table
  import sas_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  sas_tbl_wr_t           wr,
  input  logic [ANIM_BITS-1:0]  rd_addr,
  output sas_entry_t            rd_entry,
  output logic [COUNT_BITS-1:0] count
);

  sas_entry_t                entries [NUM_ANIMATIONS];
  logic [NUM_ANIMATIONS-1:0] valid;
  logic [NUM_ANIMATIONS-1:0] valid_next;

  // Entries between the old count and the new index read as zero afterwards.
  always_comb begin
    valid_next = valid;
    for (int i = 0; i < NUM_ANIMATIONS; i++) begin
      if (COUNT_BITS'(i) >= count && COUNT_BITS'(i) < {1'b0, wr.idx}) begin
        valid_next[i] = 1'b0;
      end
    end
    valid_next[wr.idx] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
    end else if (wr.en) begin
      valid <= valid_next;
      count <= {1'b0, wr.idx} + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      entries[wr.idx] <= wr.entry;
    end
  end

  assign rd_entry = (({1'b0, rd_addr} < count) && valid[rd_addr]) ? entries[rd_addr] : '0;

endmodule

// File: src/sas_core.sv
// Animation state registers and the next-state logic for one command.
`timescale 1ns / 1ps

module sas_core
  import sas_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  sas_in_t               cmd,
  input  logic [ANIM_BITS-1:0]  default_anim,
  input  logic [TILE_BITS-1:0]  tile_count,
  output logic [ANIM_BITS-1:0]  rd_addr,
  input  sas_entry_t            rd_entry,
  input  logic [COUNT_BITS-1:0] count,
  output sas_tbl_wr_t           wr,
  output sas_out_t              result
);

  logic [ANIM_BITS-1:0]  anim;
  logic [FRAME_BITS-1:0] frame;
  logic                  visible;
  logic                  auto_anim;
  sas_entry_t            cur_entry;

  logic [ANIM_BITS-1:0]  anim_next;
  logic [FRAME_BITS-1:0] frame_next;
  logic                  visible_next;
  logic                  auto_anim_next;
  sas_entry_t            cur_entry_next;
  logic                  ok;
  logic                  define_ok;
  logic                  select_hit;
  logic [FRAME_BITS:0]   frame_inc;
  logic [COUNT_BITS-1:0] anim_inc;
  sas_entry_t            new_entry;

  assign frame_inc  = {1'b0, frame} + (FRAME_BITS+1)'(1);
  assign anim_inc   = {1'b0, anim} + COUNT_BITS'(1);
  assign select_hit = {1'b0, cmd.anim_index} < count;
  assign define_ok  = ({1'b0, cmd.start_frame} <= tile_count) && (cmd.end_option <= OPT_DEFAULT);
  assign new_entry  = '{start_frame: cmd.start_frame, end_frame: cmd.end_frame,
                        end_option: cmd.end_option};

  // The table has a single read port; the address depends on which command needs it.
  always_comb begin
    if (cmd.command == CMD_SELECT) begin
      rd_addr = select_hit ? cmd.anim_index : default_anim;
    end else if (cur_entry.end_option == OPT_NEXT) begin
      rd_addr = anim_inc[ANIM_BITS-1:0];
    end else begin
      rd_addr = default_anim;
    end
  end

  always_comb begin
    anim_next      = anim;
    frame_next     = frame;
    visible_next   = visible;
    auto_anim_next = auto_anim;
    cur_entry_next = cur_entry;
    ok             = 1'b1;
    wr             = '{en: 1'b0, idx: cmd.anim_index, entry: new_entry};
    case (cmd.command)
      CMD_TICK: begin
        if (visible && auto_anim) begin
          if (frame_inc < {1'b0, cur_entry.end_frame}) begin
            frame_next = frame_inc[FRAME_BITS-1:0];
          end else begin
            case (cur_entry.end_option)
              OPT_NEXT: begin
                if (anim_inc >= count) begin
                  ok = 1'b0;
                end else begin
                  anim_next      = anim_inc[ANIM_BITS-1:0];
                  frame_next     = rd_entry.start_frame;
                  cur_entry_next = rd_entry;
                end
              end
              OPT_HOLD: begin
                frame_next     = (cur_entry.end_frame == '0) ? '0 :
                                 cur_entry.end_frame - FRAME_BITS'(1);
                auto_anim_next = 1'b0;
              end
              OPT_HIDE: begin
                frame_next   = frame_inc[FRAME_BITS-1:0];
                visible_next = 1'b0;
              end
              OPT_DEFAULT: begin
                anim_next      = default_anim;
                frame_next     = rd_entry.start_frame;
                cur_entry_next = rd_entry;
              end
              default: begin
                frame_next = cur_entry.start_frame;
              end
            endcase
          end
        end
      end
      CMD_DEFINE: begin
        ok = define_ok;
        if (define_ok) begin
          wr.en = fire;
          if (cmd.anim_index == anim) begin
            cur_entry_next = new_entry;
          end else if (anim > cmd.anim_index) begin
            cur_entry_next = '0;
          end
        end
      end
      CMD_SELECT: begin
        cur_entry_next = rd_entry;
        anim_next      = rd_addr;
        if (select_hit) begin
          frame_next = rd_entry.start_frame;
        end
      end
      CMD_STEP_BACK: begin
        if (frame <= cur_entry.start_frame) begin
          ok = 1'b0;
        end else begin
          frame_next = frame - FRAME_BITS'(1);
        end
      end
      CMD_SET_AUTO: begin
        auto_anim_next = cmd.flag_value;
      end
      CMD_SET_VISIBLE: begin
        visible_next = cmd.flag_value;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      anim      <= '0;
      frame     <= '0;
      visible   <= 1'b1;
      auto_anim <= 1'b0;
      cur_entry <= '0;
    end else if (fire) begin
      anim      <= anim_next;
      frame     <= frame_next;
      visible   <= visible_next;
      auto_anim <= auto_anim_next;
      cur_entry <= cur_entry_next;
    end
  end

  assign result = '{cur_animation: anim_next, cur_frame: frame_next, visible: visible_next,
                    auto_animate: auto_anim_next, ok: ok};

endmodule

// File: src/sas_checker.sv
// Port-level checker for the sprite animation sequencer and its bind to the top level.
`timescale 1ns / 1ps

module sas_checker
  import sas_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     cmd_valid,
  input logic     cmd_ready,
  input sas_in_t  cmd_data,
  input logic     rsp_valid,
  input logic     rsp_ready,
  input sas_out_t rsp_data
);

  logic cmd_xfer;

  assign cmd_xfer = cmd_valid && cmd_ready;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("Result changed or dropped while stalled.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("Result valid right after reset.");

  a_set_visible: assert property (@(posedge clk) disable iff (rst)
    cmd_xfer && cmd_data.command == CMD_SET_VISIBLE |=>
      rsp_valid && rsp_data.ok && rsp_data.visible == $past(cmd_data.flag_value))
    else $error("Set-visible transfer not reflected in the result.");

  a_set_auto: assert property (@(posedge clk) disable iff (rst)
    cmd_xfer && cmd_data.command == CMD_SET_AUTO |=>
      rsp_valid && rsp_data.ok && rsp_data.auto_animate == $past(cmd_data.flag_value))
    else $error("Set-auto transfer not reflected in the result.");

  a_bad_command: assert property (@(posedge clk) disable iff (rst)
    cmd_xfer && (cmd_data.command > CMD_SET_VISIBLE) |=>
      rsp_valid && !rsp_data.ok)
    else $error("Unknown command reported as legal.");

endmodule

bind sprite_animation_sequencer_top sas_checker u_sas_checker (.*);

// File: tb/sv/testbench.sv
// Self-checking testbench for the sprite animation sequencer: directed cases, then random scenes.
`timescale 1ns / 1ps

module testbench;
  import sas_pkg::*;

  localparam logic [CMD_BITS-1:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [CMD_BITS-1:0] CMD_UNUSED_7 = 3'd7;
  localparam logic [OPT_BITS-1:0] OPT_UNUSED   = 3'd7;
  localparam int IDLE_PCT    = 27;
  localparam int QUIET_LIMIT = 5000;
  localparam int PHASE_ITEMS = 310;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cmd_valid = 1'b0;
  logic                      cmd_ready;
  sas_in_t                   cmd_data = '0;
  logic                      rsp_valid;
  logic                      rsp_ready = 1'b0;
  sas_out_t                  rsp_data;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  logic calm = 1'b0;
  int   mismatches = 0;
  int   items_sent = 0;
  int   quiet_cycles = 0;

  sas_entry_t             seq_tbl [NUM_ANIMATIONS];
  logic [COUNT_BITS-1:0]  n_defined;
  logic [ANIM_BITS-1:0]   anim_q;
  logic [FRAME_BITS-1:0]  frame_q;
  logic                   shown_q;
  logic                   auto_q;
  logic [ANIM_BITS-1:0]   dflt_anim;
  logic [TILE_BITS-1:0]   tiles;

  sas_out_t sprite_status_q [$];
  sas_out_t want;

  sprite_animation_sequencer_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_data  (cmd_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic sas_entry_t entry_at(input logic [ANIM_BITS-1:0] idx);
    if ({1'b0, idx} < n_defined) begin
      return seq_tbl[idx];
    end
    return '0;
  endfunction

  function automatic sas_out_t sequence_step(input sas_in_t c);
    sas_out_t               r;
    sas_entry_t             e;
    logic [FRAME_BITS:0]    nxt;
    logic                   ok;
    ok = 1'b1;
    case (c.command)
      CMD_TICK: begin
        if (shown_q && auto_q) begin
          e = entry_at(anim_q);
          nxt = {1'b0, frame_q} + 1'b1;
          if (nxt < {1'b0, e.end_frame}) begin
            frame_q = nxt[FRAME_BITS-1:0];
          end else begin
            case (e.end_option)
              OPT_NEXT: begin
                if ({1'b0, anim_q} + 1'b1 >= n_defined) begin
                  ok = 1'b0;
                end else begin
                  anim_q = anim_q + 1'b1;
                  frame_q = entry_at(anim_q).start_frame;
                end
              end
              OPT_HOLD: begin
                frame_q = (e.end_frame == '0) ? '0 : e.end_frame - 1'b1;
                auto_q = 1'b0;
              end
              OPT_HIDE: begin
                frame_q = nxt[FRAME_BITS-1:0];
                shown_q = 1'b0;
              end
              OPT_DEFAULT: begin
                anim_q = dflt_anim;
                frame_q = entry_at(anim_q).start_frame;
              end
              default: frame_q = e.start_frame;
            endcase
          end
        end
      end
      CMD_DEFINE: begin
        if ({1'b0, c.start_frame} > tiles || c.end_option > OPT_DEFAULT) begin
          ok = 1'b0;
        end else begin
          for (int i = n_defined; i < c.anim_index; i++) seq_tbl[i] = '0;
          seq_tbl[c.anim_index] = '{c.start_frame, c.end_frame, c.end_option};
          n_defined = {1'b0, c.anim_index} + 1'b1;
        end
      end
      CMD_SELECT: begin
        if ({1'b0, c.anim_index} < n_defined) begin
          anim_q = c.anim_index;
          frame_q = entry_at(anim_q).start_frame;
        end else begin
          anim_q = dflt_anim;
        end
      end
      CMD_STEP_BACK: begin
        if (frame_q <= entry_at(anim_q).start_frame) ok = 1'b0;
        else frame_q = frame_q - 1'b1;
      end
      CMD_SET_AUTO: auto_q = c.flag_value;
      CMD_SET_VISIBLE: shown_q = c.flag_value;
      default: ok = 1'b0;
    endcase
    r.cur_animation = anim_q;
    r.cur_frame = frame_q;
    r.visible = shown_q;
    r.auto_animate = auto_q;
    r.ok = ok;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_ANIMATIONS; i++) seq_tbl[i] = '0;
      n_defined = '0;
      anim_q = '0;
      frame_q = '0;
      shown_q = 1'b1;
      auto_q = 1'b0;
      dflt_anim = '0;
      tiles = TILE_COUNT_RESET;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (sprite_status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Result with nothing expected: %p", rsp_data);
        end else begin
          want = sprite_status_q.pop_front();
          if (rsp_data.cur_animation !== want.cur_animation ||
              rsp_data.cur_frame !== want.cur_frame ||
              rsp_data.visible !== want.visible ||
              rsp_data.auto_animate !== want.auto_animate ||
              rsp_data.ok !== want.ok) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Mismatch at %0t: expected anim %0d frame %0d vis %b auto %b ok %b",
                       $realtime, want.cur_animation, want.cur_frame, want.visible,
                       want.auto_animate, want.ok);
              $display("  got anim %0d frame %0d vis %b auto %b ok %b",
                       rsp_data.cur_animation, rsp_data.cur_frame, rsp_data.visible,
                       rsp_data.auto_animate, rsp_data.ok);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_DEFAULT_ANIM) dflt_anim = cfg_data[ANIM_BITS-1:0];
        else tiles = cfg_data;
      end
      if (cmd_valid && cmd_ready) sprite_status_q.push_back(sequence_step(cmd_data));
    end
  end

  always @(posedge clk) begin
    rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic sas_in_t mk_cmd(input logic [CMD_BITS-1:0] op,
                                     input logic [ANIM_BITS-1:0] idx,
                                     input logic [FRAME_BITS-1:0] st,
                                     input logic [FRAME_BITS-1:0] en,
                                     input logic [OPT_BITS-1:0] opt,
                                     input logic flag);
    sas_in_t c;
    c.command = op;
    c.anim_index = idx;
    c.start_frame = st;
    c.end_frame = en;
    c.end_option = opt;
    c.flag_value = flag;
    return c;
  endfunction

  function automatic sas_in_t rand_item();
    logic [$bits(sas_in_t)-1:0] bits;
    bits = $bits(sas_in_t)'($urandom);
    return sas_in_t'(bits);
  endfunction

  task automatic send_cmd(input sas_in_t c);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_data <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (!cmd_ready);
    items_sent++;
  endtask

  task automatic settle();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (sprite_status_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_idle_state();
    send_cmd(mk_cmd(CMD_TICK, 4'd0, 8'd0, 8'd0, OPT_LOOP, 1'b0));
    send_cmd(mk_cmd(CMD_STEP_BACK, 4'd0, 8'd0, 8'd0, OPT_LOOP, 1'b0));
    send_cmd(mk_cmd(CMD_UNUSED_6, 4'd0, 8'd0, 8'd0, OPT_LOOP, 1'b0));
    send_cmd(mk_cmd(CMD_UNUSED_7, 4'hF, 8'hFF, 8'hFF, OPT_UNUSED, 1'b1));
    send_cmd(mk_cmd(CMD_SELECT, 4'd9, 8'd0, 8'd0, OPT_LOOP, 1'b0));
  endtask

  task automatic test_define_rules();
    send_cmd(mk_cmd(CMD_DEFINE, 4'd0, 8'd2, 8'd4, OPT_LOOP, 1'b0));
    send_cmd(mk_cmd(CMD_DEFINE, 4'd2, 8'd255, 8'd0, OPT_HIDE, 1'b0));
    send_cmd(mk_cmd(CMD_DEFINE, 4'd3, 8'd0, 8'd255, OPT_UNUSED, 1'b0));
    send_cmd(mk_cmd(CMD_SELECT, 4'd1, 8'd0, 8'd0, OPT_LOOP, 1'b0));
    send_cmd(mk_cmd(CMD_SELECT, 4'd15, 8'd0, 8'd0, OPT_LOOP, 1'b0));
  endtask

  task automatic test_end_options();
    send_cmd(mk_cmd(CMD_SET_AUTO, 4'd0, 8'd0, 8'd0, OPT_LOOP, 1'b1));
    send_cmd(mk_cmd(CMD_SELECT, 4'd0, 8'd0, 8'd0, OPT_LOOP, 1'b0));
    send_cmd(mk_cmd(CMD_TICK, 4'd0, 8'd0, 8'd0, OPT_LOOP, 1'b0));
    send_cmd(mk_cmd(CMD_STEP_BACK, 4'd0, 8'd0, 8'd0, OPT_LOOP, 1'b0));
    send_cmd(mk_cmd(CMD_TICK, 4'd0, 8'd0, 8'd0, OPT_LOOP, 1'b0));
    send_cmd(mk_cmd(CMD_TICK, 4'd0, 8'd0, 8'd0, OPT_LOOP, 1'b0));
    send_cmd(mk_cmd(CMD_SELECT, 4'd2, 8'd0, 8'd0, OPT_LOOP, 1'b0));
    send_cmd(mk_cmd(CMD_TICK, 4'd0, 8'd0, 8'd0, OPT_LOOP, 1'b0));
    send_cmd(mk_cmd(CMD_TICK, 4'd0, 8'd0, 8'd0, OPT_LOOP, 1'b0));
    send_cmd(mk_cmd(CMD_SET_VISIBLE, 4'd0, 8'd0, 8'd0, OPT_LOOP, 1'b1));
    send_cmd(mk_cmd(CMD_DEFINE, 4'd3, 8'd10, 8'd11, OPT_NEXT, 1'b0));
    send_cmd(mk_cmd(CMD_DEFINE, 4'd4, 8'd20, 8'd0, OPT_DEFAULT, 1'b0));
    send_cmd(mk_cmd(CMD_SELECT, 4'd3, 8'd0, 8'd0, OPT_LOOP, 1'b0));
    send_cmd(mk_cmd(CMD_TICK, 4'd0, 8'd0, 8'd0, OPT_LOOP, 1'b0));
    send_cmd(mk_cmd(CMD_TICK, 4'd0, 8'd0, 8'd0, OPT_LOOP, 1'b0));
    send_cmd(mk_cmd(CMD_DEFINE, 4'd5, 8'd7, 8'd8, OPT_NEXT, 1'b0));
    send_cmd(mk_cmd(CMD_SELECT, 4'd5, 8'd0, 8'd0, OPT_LOOP, 1'b0));
    send_cmd(mk_cmd(CMD_TICK, 4'd0, 8'd0, 8'd0, OPT_LOOP, 1'b0));
    send_cmd(mk_cmd(CMD_DEFINE, 4'd1, 8'd5, 8'd6, OPT_HOLD, 1'b0));
    send_cmd(mk_cmd(CMD_SELECT, 4'd1, 8'd0, 8'd0, OPT_LOOP, 1'b0));
    send_cmd(mk_cmd(CMD_TICK, 4'd0, 8'd0, 8'd0, OPT_LOOP, 1'b0));
    send_cmd(mk_cmd(CMD_SET_AUTO, 4'd0, 8'd0, 8'd0, OPT_LOOP, 1'b1));
    send_cmd(mk_cmd(CMD_DEFINE, 4'd0, 8'd0, 8'd0, OPT_HOLD, 1'b0));
    send_cmd(mk_cmd(CMD_SELECT, 4'd0, 8'd0, 8'd0, OPT_LOOP, 1'b0));
    send_cmd(mk_cmd(CMD_TICK, 4'd0, 8'd0, 8'd0, OPT_LOOP, 1'b0));
  endtask

  task automatic test_registers();
    settle();
    write_reg(CFG_TILE_COUNT, 9'd0);
    send_cmd(mk_cmd(CMD_DEFINE, 4'd0, 8'd1, 8'd3, OPT_LOOP, 1'b0));
    send_cmd(mk_cmd(CMD_DEFINE, 4'd0, 8'd0, 8'd3, OPT_LOOP, 1'b0));
    settle();
    write_reg(CFG_DEFAULT_ANIM, 9'd15);
    send_cmd(mk_cmd(CMD_SELECT, 4'd6, 8'd0, 8'd0, OPT_LOOP, 1'b0));
    send_cmd(mk_cmd(CMD_SET_AUTO, 4'd0, 8'd0, 8'd0, OPT_LOOP, 1'b1));
    send_cmd(mk_cmd(CMD_TICK, 4'd0, 8'd0, 8'd0, OPT_LOOP, 1'b0));
    settle();
    write_reg(CFG_TILE_COUNT, 9'd256);
    write_reg(CFG_DEFAULT_ANIM, 9'd0);
  endtask

  task automatic play_scene();
    int                    k;
    int                    r;
    logic [FRAME_BITS-1:0] st;
    sas_in_t               c;
    k = $urandom_range(1, NUM_ANIMATIONS);
    for (int i = 0; i < k; i++) begin
      c = rand_item();
      st = ($urandom_range(9) == 0) ? FRAME_BITS'($urandom) : FRAME_BITS'($urandom_range(0, 200));
      c.command = CMD_DEFINE;
      c.anim_index = ANIM_BITS'(i);
      c.start_frame = st;
      c.end_frame = st + FRAME_BITS'($urandom_range(1, 6));
      c.end_option = OPT_BITS'($urandom_range(0, 4));
      send_cmd(c);
    end
    c = rand_item();
    c.command = CMD_SET_AUTO;
    c.flag_value = 1'b1;
    send_cmd(c);
    c = rand_item();
    c.command = CMD_SET_VISIBLE;
    c.flag_value = 1'b1;
    send_cmd(c);
    c = rand_item();
    c.command = CMD_SELECT;
    c.anim_index = ANIM_BITS'($urandom_range(0, k - 1));
    send_cmd(c);
    repeat ($urandom_range(40, 100)) begin
      c = rand_item();
      r = $urandom_range(99);
      if (r < 60) begin
        c.command = CMD_TICK;
      end else if (r < 68) begin
        c.command = CMD_SELECT;
        c.anim_index = ANIM_BITS'($urandom_range(0, k));
      end else if (r < 74) begin
        c.command = CMD_STEP_BACK;
      end else if (r < 80) begin
        c.command = CMD_SET_AUTO;
        c.flag_value = ($urandom_range(3) != 0);
      end else if (r < 86) begin
        c.command = CMD_SET_VISIBLE;
        c.flag_value = ($urandom_range(3) != 0);
      end else if (r < 92) begin
        c.command = CMD_DEFINE;
      end
      send_cmd(c);
    end
  endtask

  task automatic test_random_scenes();
    logic [CFG_DATA_BITS-1:0] dflt;
    logic [CFG_DATA_BITS-1:0] tc;
    int                       target;
    target = items_sent;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin dflt = 9'd3;  tc = 9'd256; end
        1: begin dflt = 9'd15; tc = 9'd255; end
        2: begin dflt = 9'd0;  tc = 9'd128; end
        4: begin dflt = 9'd9;  tc = 9'd256; end
        default: begin
          dflt = CFG_DATA_BITS'($urandom_range(0, 15));
          tc = CFG_DATA_BITS'($urandom_range(0, 256));
        end
      endcase
      settle();
      write_reg(CFG_DEFAULT_ANIM, dflt);
      write_reg(CFG_TILE_COUNT, tc);
      calm <= (phase == 2);
      target += PHASE_ITEMS;
      while (items_sent < target) play_scene();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_idle_state();
    test_define_rules();
    test_end_options();
    test_registers();
    test_random_scenes();
    settle();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sprite_animation_sequencer_top.f
src/sas_pkg.sv
src/sas_seq_table.sv
src/sas_core.sv
src/sprite_animation_sequencer_top.sv
src/sas_checker.sv
tb/sv/testbench.sv
